@@ hdl/esm_pkg.sv @@
// ----------------------------------------------------------------------------
// esm_pkg
// Types, constants and shared arithmetic for the scaled Euler transform
// matrix generator.
// ----------------------------------------------------------------------------
package esm_pkg;

  // trig iteration count and output fraction bits
  localparam int TRIG_ITERATIONS = 16;
  localparam int OUT_FRAC_BITS   = 16;

  // lane organization
  localparam int NUM_LANES       = 3;
  localparam int LANE_STEPS      = 6;
  localparam int CORDIC_PER_STEP = 4;
  localparam int DIV_BITS        = 6;
  localparam int DIV_W           = DIV_BITS * (LANE_STEPS + 1);
  localparam int STEP_W          = $clog2(LANE_STEPS);
  localparam int ITER_W          = $clog2(LANE_STEPS * CORDIC_PER_STEP);

  // output sequence
  localparam int NUM_COLS  = 7;
  localparam int COL_W     = $clog2(NUM_COLS);
  localparam int MODEL_COLS = 4;
  localparam logic [COL_W-1:0] COL_TRANS = COL_W'(3);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(NUM_COLS - 1);

  // matrix kind codes
  localparam logic KIND_MODEL  = 1'b0;
  localparam logic KIND_NORMAL = 1'b1;

  // angle constants, Q6.30
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // reciprocal of a zero scale
  localparam logic signed [DIV_W-1:0] INV_ZERO = DIV_W'(64'd1 << 40);

  typedef logic signed [33:0] esm_q30_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
    logic signed [31:0] translate_x;
    logic signed [31:0] translate_y;
    logic signed [31:0] translate_z;
  } esm_in_t;

  typedef struct packed {
    logic               matrix_kind;
    logic [1:0]         column_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic               zero_scale;
    logic               last;
  } esm_out_t;

  // lane sequencing from the top level
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } esm_lane_ctrl_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    esm_q30_t                 sin_v;
    esm_q30_t                 cos_v;
    logic signed [23:0]       scale;
    logic signed [DIV_W-1:0]  inv;
    logic signed [31:0]       trans;
  } esm_lane_res_t;

  // finished rotation plus everything the emitter needs
  typedef struct packed {
    logic [2:0][2:0][33:0]      rot;
    logic [2:0][23:0]           scale;
    logic [2:0][DIV_W-1:0]      inv;
    logic [2:0][31:0]           trans;
    logic                       zero_scale;
  } esm_item_t;

  // arctangent table, Q2.30
  function automatic esm_q30_t atan_q30(logic [ITER_W-1:0] i);
    esm_q30_t v;
    unique case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043836;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048576;
      5'd11:   v = 34'sd524288;
      5'd12:   v = 34'sd262144;
      5'd13:   v = 34'sd131072;
      5'd14:   v = 34'sd65536;
      5'd15:   v = 34'sd32768;
      5'd16:   v = 34'sd16384;
      5'd17:   v = 34'sd8192;
      5'd18:   v = 34'sd4096;
      5'd19:   v = 34'sd2048;
      5'd20:   v = 34'sd1024;
      5'd21:   v = 34'sd512;
      5'd22:   v = 34'sd256;
      5'd23:   v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 product, rounded to nearest
  function automatic esm_q30_t mul30(esm_q30_t a, esm_q30_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    p = p + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

endpackage

@@ hdl/esm_lane.sv @@
// ----------------------------------------------------------------------------
// esm_lane
// One axis lane: CORDIC sine/cosine of the angle and the rounded reciprocal
// of the scale, six quotient bits per load or step cycle.
// ----------------------------------------------------------------------------
module esm_lane (
  input  logic                   clk,
  input  esm_pkg::esm_lane_ctrl_t ctrl,
  input  logic signed [15:0]     angle,
  input  logic signed [23:0]     scale,
  input  logic signed [31:0]     trans,
  output esm_pkg::esm_lane_res_t res
);
  import esm_pkg::*;

  // six restoring division steps
  function automatic logic [29:0] div_group(logic [23:0] rem_in, logic [5:0] bits,
                                            logic [23:0] mag);
    logic [24:0] t;
    logic [23:0] rem;
    logic [5:0]  q;
    rem = rem_in;
    q   = '0;
    for (int u = DIV_BITS - 1; u >= 0; u--) begin
      t = {rem, bits[u]};
      if (t >= {1'b0, mag}) begin
        t    = t - {1'b0, mag};
        q[u] = 1'b1;
      end
      rem = t[23:0];
    end
    return {rem, q};
  endfunction

  esm_q30_t             x_r, y_r, z_r;
  logic                 neg_r;
  logic signed [23:0]   scale_r;
  logic signed [31:0]   trans_r;
  logic                 zero_r, sneg_r;
  logic [23:0]          mag_r, rem_r;
  logic [DIV_W-1:0]     dvd_r, quo_r;

  logic signed [35:0]   a_ext, a_one, a_two;
  logic                 neg_ld;
  logic [23:0]          mag_ld;
  logic [DIV_W-1:0]     dvd_ld;
  logic [29:0]          grp_ld, grp_st;
  esm_q30_t             x_nxt, y_nxt, z_nxt;

  // angle into [-pi/2, pi/2] with a sign flag
  always_comb begin
    a_ext = {{2{angle[15]}}, angle, 18'b0};
    if (a_ext > PI_Q30) begin
      a_one = a_ext - TWO_PI_Q30;
    end else if (a_ext < -PI_Q30) begin
      a_one = a_ext + TWO_PI_Q30;
    end else begin
      a_one = a_ext;
    end
    neg_ld = 1'b1;
    if (a_one > HALF_PI_Q30) begin
      a_two = a_one - PI_Q30;
    end else if (a_one < -HALF_PI_Q30) begin
      a_two = a_one + PI_Q30;
    end else begin
      a_two  = a_one;
      neg_ld = 1'b0;
    end
  end

  // divider setup, first quotient group and the quotient group of a step
  always_comb begin
    mag_ld = scale[23] ? 24'(-scale) : 24'(scale);
    dvd_ld = (DIV_W'(1) << 40) + DIV_W'(mag_ld[23:1]);
    grp_ld = div_group(24'd0, dvd_ld[DIV_W-1 -: DIV_BITS], mag_ld);
    grp_st = div_group(rem_r, dvd_r[DIV_W-1 -: DIV_BITS], mag_r);
  end

  // four rotations per step cycle, none past TRIG_ITERATIONS
  always_comb begin
    esm_q30_t          xs, ys;
    logic [ITER_W-1:0] it;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    for (int u = 0; u < CORDIC_PER_STEP; u++) begin
      it = ITER_W'(int'(ctrl.idx) * CORDIC_PER_STEP + u);
      xs = x_nxt >>> it;
      ys = y_nxt >>> it;
      if (int'(it) < TRIG_ITERATIONS) begin
        if (!z_nxt[33]) begin
          x_nxt = x_nxt - ys;
          y_nxt = y_nxt + xs;
          z_nxt = z_nxt - atan_q30(it);
        end else begin
          x_nxt = x_nxt + ys;
          y_nxt = y_nxt - xs;
          z_nxt = z_nxt + atan_q30(it);
        end
      end
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r     <= CORDIC_GAIN;
      y_r     <= '0;
      z_r     <= a_two[33:0];
      neg_r   <= neg_ld;
      scale_r <= scale;
      trans_r <= trans;
      zero_r  <= (scale == 24'sd0);
      sneg_r  <= scale[23];
      mag_r   <= mag_ld;
      rem_r   <= grp_ld[29:6];
      dvd_r   <= dvd_ld << DIV_BITS;
      quo_r   <= DIV_W'(grp_ld[5:0]);
    end else if (ctrl.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      rem_r <= grp_st[29:6];
      dvd_r <= dvd_r << DIV_BITS;
      quo_r <= {quo_r[DIV_W-DIV_BITS-1:0], grp_st[5:0]};
    end
  end

  // results
  always_comb begin
    res.sin_v = neg_r ? -y_r : y_r;
    res.cos_v = neg_r ? -x_r : x_r;
    res.scale = scale_r;
    res.trans = trans_r;
    if (zero_r) begin
      res.inv = INV_ZERO;
    end else if (sneg_r) begin
      res.inv = -$signed(quo_r);
    end else begin
      res.inv = $signed(quo_r);
    end
  end

endmodule

@@ hdl/esm_merge.sv @@
// ----------------------------------------------------------------------------
// esm_merge
// Combines the three lanes into the Y-X-Z rotation over two product stages.
// ----------------------------------------------------------------------------
module esm_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   lane_valid,
  output logic                   lane_ready,
  input  esm_pkg::esm_lane_res_t lanes [esm_pkg::NUM_LANES],
  output logic                   item_valid,
  input  logic                   item_ready,
  output esm_pkg::esm_item_t     item
);
  import esm_pkg::*;

  logic     m1_v_r, m2_v_r;
  logic     m1_take, m2_take, m2_ready;
  esm_q30_t c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c1s3_r, c2c3_r, s1s3_r;
  esm_q30_t c2s1_r, c1c2_r, s2_r, s3_r;
  logic [2:0][23:0]      sc_r;
  logic [2:0][DIV_W-1:0] inv_r;
  logic [2:0][31:0]      tr_r;
  logic                  zf_r;
  esm_item_t             item_r;
  esm_q30_t s1, c1, s2, c2, s3, c3;

  // pitch lane 0, yaw lane 1, roll lane 2
  assign s2 = lanes[0].sin_v;
  assign c2 = lanes[0].cos_v;
  assign s1 = lanes[1].sin_v;
  assign c1 = lanes[1].cos_v;
  assign s3 = lanes[2].sin_v;
  assign c3 = lanes[2].cos_v;

  // handshake between the two stages
  assign m2_ready   = !m2_v_r || item_ready;
  assign m2_take    = m1_v_r && m2_ready;
  assign lane_ready = !m1_v_r || m2_ready;
  assign m1_take    = lane_valid && lane_ready;
  assign item_valid = m2_v_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else begin
      if (lane_ready) begin
        m1_v_r <= lane_valid;
      end
      if (m2_ready) begin
        m2_v_r <= m1_v_r;
      end
    end
  end

  // first products
  always_ff @(posedge clk) begin
    if (m1_take) begin
      c1c3_r <= mul30(c1, c3);
      s1s2_r <= mul30(s1, s2);
      c2s3_r <= mul30(c2, s3);
      c1s2_r <= mul30(c1, s2);
      c3s1_r <= mul30(c3, s1);
      c1s3_r <= mul30(c1, s3);
      c2c3_r <= mul30(c2, c3);
      s1s3_r <= mul30(s1, s3);
      c2s1_r <= mul30(c2, s1);
      c1c2_r <= mul30(c1, c2);
      s2_r   <= s2;
      s3_r   <= s3;
      for (int k = 0; k < NUM_LANES; k++) begin
        sc_r[k]  <= lanes[k].scale;
        inv_r[k] <= lanes[k].inv;
        tr_r[k]  <= lanes[k].trans;
      end
      zf_r <= (lanes[0].scale == 24'sd0) || (lanes[1].scale == 24'sd0) ||
              (lanes[2].scale == 24'sd0);
    end
  end

  // second products and the rotation sums
  always_ff @(posedge clk) begin
    if (m2_take) begin
      item_r.rot[0][0] <= c1c3_r + mul30(s1s2_r, s3_r);
      item_r.rot[0][1] <= c2s3_r;
      item_r.rot[0][2] <= mul30(c1s2_r, s3_r) - c3s1_r;
      item_r.rot[1][0] <= mul30(c3s1_r, s2_r) - c1s3_r;
      item_r.rot[1][1] <= c2c3_r;
      item_r.rot[1][2] <= mul30(c1c3_r, s2_r) + s1s3_r;
      item_r.rot[2][0] <= c2s1_r;
      item_r.rot[2][1] <= -s2_r;
      item_r.rot[2][2] <= c1c2_r;
      item_r.scale      <= sc_r;
      item_r.inv        <= inv_r;
      item_r.trans      <= tr_r;
      item_r.zero_scale <= zf_r;
    end
  end

endmodule

@@ hdl/esm_emit.sv @@
// ----------------------------------------------------------------------------
// esm_emit
// Sends the seven columns of one item, one per cycle unless the output stalls,
// through a product stage and the output register.
// ----------------------------------------------------------------------------
module esm_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  esm_pkg::esm_item_t item,
  output logic               out_valid,
  input  logic               out_stall,
  output esm_pkg::esm_out_t  out_data
);
  import esm_pkg::*;

  localparam int MSH = 46 - OUT_FRAC_BITS;
  localparam int NSH = 44 - OUT_FRAC_BITS;
  localparam int UP  = (OUT_FRAC_BITS > 16) ? OUT_FRAC_BITS - 16 : 0;
  localparam int DN  = (OUT_FRAC_BITS < 16) ? 16 - OUT_FRAC_BITS : 0;
  localparam logic signed [67:0] M_HALF  = (68'sd1 <<< MSH) >>> 1;
  localparam logic signed [67:0] N_HALF  = (68'sd1 <<< NSH) >>> 1;
  localparam logic signed [67:0] DN_HALF = (68'sd1 <<< DN) >>> 1;
  localparam logic signed [31:0] ONE_OUT = 32'(64'd1 << OUT_FRAC_BITS);

  function automatic logic signed [31:0] sat32(logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic                  en, take, busy_r;
  logic [COL_W-1:0]      col_r;
  esm_item_t             item_r;
  logic [1:0]            krow;
  logic                  p_v_r;
  logic [COL_W-1:0]      p_col_r;
  logic signed [57:0]    pm_r [3];
  logic signed [65:0]    pn_r [3];
  logic signed [31:0]    pt_r [3];
  logic                  p_zf_r;
  logic                  out_valid_r;
  esm_out_t              out_r, out_nxt;
  logic signed [31:0]    el [3];

  // a full, stalled output register freezes the pipe
  assign en         = !(out_valid_r && out_stall);
  assign item_ready = !busy_r || (col_r == COL_LAST && en);
  assign take       = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // column sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      col_r  <= '0;
    end else if (en && busy_r) begin
      if (col_r == COL_LAST) begin
        busy_r <= 1'b0;
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item;
    end
  end

  // rotation row used by this column
  always_comb begin
    if (col_r >= COL_W'(MODEL_COLS)) begin
      krow = 2'(col_r - COL_W'(MODEL_COLS));
    end else if (col_r == COL_TRANS) begin
      krow = 2'd0;
    end else begin
      krow = col_r[1:0];
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [33:0] rr;
    if (en && busy_r) begin
      p_col_r <= col_r;
      p_zf_r  <= item_r.zero_scale;
      for (int j = 0; j < 3; j++) begin
        rr       = $signed(item_r.rot[krow][j]) + 34'sd512;
        pm_r[j]  <= 58'($signed(item_r.scale[krow])) * 58'($signed(item_r.rot[krow][j]));
        pn_r[j]  <= 66'($signed(item_r.inv[krow])) * 66'($signed(rr[33:10]));
        pt_r[j]  <= $signed(item_r.trans[j]);
      end
    end
  end

  // rounding, saturation and column assembly
  always_comb begin
    logic signed [67:0] t;
    for (int j = 0; j < 3; j++) begin
      if (p_col_r >= COL_W'(MODEL_COLS)) begin
        t = (68'(pn_r[j]) + N_HALF) >>> NSH;
      end else if (p_col_r == COL_TRANS) begin
        if (UP > 0) begin
          t = 68'(pt_r[j]) <<< UP;
        end else begin
          t = (68'(pt_r[j]) + DN_HALF) >>> DN;
        end
      end else begin
        t = (68'(pm_r[j]) + M_HALF) >>> MSH;
      end
      el[j] = sat32(t);
    end
    out_nxt.elem_x = el[0];
    out_nxt.elem_y = el[1];
    out_nxt.elem_z = el[2];
    if (p_col_r >= COL_W'(MODEL_COLS)) begin
      out_nxt.matrix_kind  = KIND_NORMAL;
      out_nxt.column_index = 2'(p_col_r - COL_W'(MODEL_COLS));
      out_nxt.elem_w       = '0;
      out_nxt.zero_scale   = p_zf_r;
    end else begin
      out_nxt.matrix_kind  = KIND_MODEL;
      out_nxt.column_index = p_col_r[1:0];
      out_nxt.elem_w       = (p_col_r == COL_TRANS) ? ONE_OUT : 32'sd0;
      out_nxt.zero_scale   = 1'b0;
    end
    out_nxt.last = (p_col_r == COL_LAST);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p_v_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ hdl/euler_scale_transform_matrix.sv @@
// ----------------------------------------------------------------------------
// euler_scale_transform_matrix
// Scaled Y-X-Z Euler rotation: emits four model-matrix columns and three
// normal-matrix columns for each input beat.
// ----------------------------------------------------------------------------
//   channel   ports                        beat
//   input     in_valid  in_stall  in_data    angles, scales, translation
//   output    out_valid out_stall out_data   one matrix column
//
// the lanes take a new input beat once they hand off the last one; the rate
// is set by the lanes (a load plus six steps: four CORDIC rotations and six
// reciprocal quotient bits per step) and by the emitter sending seven
// columns at one per cycle while out_stall is low.
// synchronous active-low reset clears all valid, busy and counter state.
// out_stall freezes the emitter; back pressure reaches in_stall via merge.
module euler_scale_transform_matrix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  esm_pkg::esm_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output esm_pkg::esm_out_t out_data
);
  import esm_pkg::*;

  logic                busy_r, done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                in_acc, hand, lane_ready;
  esm_lane_ctrl_t      ctrl;
  esm_lane_res_t       lane_res [NUM_LANES];
  logic signed [15:0]  angle_in [NUM_LANES];
  logic signed [23:0]  scale_in [NUM_LANES];
  logic signed [31:0]  trans_in [NUM_LANES];
  logic                item_valid, item_ready;
  esm_item_t           item;

  // lane sequencing
  assign hand     = done_r && lane_ready;
  assign in_stall = busy_r && !hand;
  assign in_acc   = in_valid && !in_stall;

  assign ctrl.load = in_acc;
  assign ctrl.step = busy_r && !done_r;
  assign ctrl.idx  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (hand) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (ctrl.step) begin
      if (cnt_r == STEP_W'(LANE_STEPS - 1)) begin
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + STEP_W'(1);
      end
    end
  end

  // per-axis operands
  assign angle_in[0] = in_data.angle_x;
  assign angle_in[1] = in_data.angle_y;
  assign angle_in[2] = in_data.angle_z;
  assign scale_in[0] = in_data.scale_x;
  assign scale_in[1] = in_data.scale_y;
  assign scale_in[2] = in_data.scale_z;
  assign trans_in[0] = in_data.translate_x;
  assign trans_in[1] = in_data.translate_y;
  assign trans_in[2] = in_data.translate_z;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    esm_lane u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .angle (angle_in[g]),
      .scale (scale_in[g]),
      .trans (trans_in[g]),
      .res   (lane_res[g])
    );
  end

  esm_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (done_r),
    .lane_ready (lane_ready),
    .lanes      (lane_res),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  esm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> busy_r) else $error("lane done without busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= STEP_W'(LANE_STEPS - 1)) else $error("lane step count out of range");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !done_r && !in_acc && cnt_r == STEP_W'(LANE_STEPS - 1)) |=> done_r)
    else $error("lane did not finish after last step");
`endif

endmodule
